// ===== hdl/oqsc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oqsc_pkg
// Shared constants and controller/datapath interface types for the
// output-queued switch congestion core.
// ----------------------------------------------------------------------------
package oqsc_pkg;

    localparam int MAX_PORTS_DEF   = 16;
    localparam int INPUT_DEPTH_DEF = 64;
    localparam int COUNT_MAX       = 2047;
    localparam int CNT_W           = 11;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 40;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 5;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PORT_COUNT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DELAY      = 1'd1;

    // item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_TICK = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic latch;
        logic push;
        logic tick_step;
        logic pop_apply;
        logic drain_step;
        logic snap_eval;
        logic emit;
    } oqsc_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       drain_pend;
        logic       sweep_last;
        logic       out_free;
    } oqsc_sts_t;

endpackage
`default_nettype wire

// ===== hdl/oqsc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oqsc_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module oqsc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/oqsc_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oqsc_ctrl
// Sequencer: accepts one transaction, steps the datapath through it.
// ----------------------------------------------------------------------------
module oqsc_ctrl import oqsc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    input  wire oqsc_sts_t sts,
    output oqsc_cmd_t      cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_TICK,
        S_POP,
        S_DRAIN,
        S_SNAP,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (sts.kind == KIND_LOAD) begin
                    cmd.push   = 1'b1;
                    state_next = S_RESP;
                end else if (sts.kind == KIND_TICK) begin
                    state_next = S_TICK;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_TICK: begin
                cmd.tick_step = 1'b1;
                state_next    = S_POP;
            end
            S_POP: begin
                cmd.pop_apply = 1'b1;
                state_next    = sts.drain_pend ? S_DRAIN : S_SNAP;
            end
            S_DRAIN: begin
                cmd.drain_step = 1'b1;
                if (sts.sweep_last) begin
                    state_next = S_SNAP;
                end
            end
            S_SNAP: begin
                cmd.snap_eval = 1'b1;
                state_next    = S_RESP;
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

// ===== hdl/oqsc_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// oqsc_datapath
// Input FIFOs, output counters, snapshot, drain sweep and result register.
// ----------------------------------------------------------------------------
module oqsc_datapath import oqsc_pkg::*; #(
    parameter int MAX_PORTS   = MAX_PORTS_DEF,
    parameter int INPUT_DEPTH = INPUT_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic [1:0]            s_tuser,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  m_tready,
    output logic                       m_tvalid,
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire oqsc_cmd_t             cmd,
    output oqsc_sts_t                  sts
);

    localparam int PW   = $clog2(MAX_PORTS);
    localparam int NW   = $clog2(MAX_PORTS + 1);
    localparam int CW   = (NW > 5) ? NW : 5;
    localparam int HW   = $clog2(INPUT_DEPTH);
    localparam int FW   = $clog2(INPUT_DEPTH + 1);
    localparam int AW   = $clog2(MAX_PORTS * INPUT_DEPTH);
    localparam int TW   = $clog2(15 * MAX_PORTS + 1);
    localparam int TOTW = $clog2(MAX_PORTS * COUNT_MAX + 1);

    logic [4:0]       port_count_reg;
    logic [3:0]       delay_reg;
    logic [1:0]       kind_reg;
    logic [3:0]       port_reg;
    logic [4:0]       dest_reg;
    logic [HW-1:0]    head_reg [MAX_PORTS];
    logic [FW-1:0]    fill_reg [MAX_PORTS];
    logic [CNT_W-1:0] cnt_reg  [MAX_PORTS];
    logic [CNT_W-1:0] snap_reg [MAX_PORTS];
    logic [TOTW-1:0]  tot_reg;
    logic [CNT_W-1:0] cur_reg;
    logic [CNT_W-1:0] max_reg;
    logic [PW-1:0]    ptr_reg;
    logic [TW-1:0]    ticks_reg;
    logic [PW-1:0]    sweep_reg;
    logic             pop_pend_reg;
    logic             drain_pend_reg;
    logic [1:0]       status_reg;
    logic             upd_reg;
    logic             m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [CW-1:0]    n_c;
    logic [CW-1:0]    pc_ext;
    logic             port_bad;
    logic             ld_bad;
    logic             ld_full;
    logic [PW-1:0]    pi;
    logic [HW:0]      slot_sum;
    logic [HW-1:0]    slot;
    logic [PW-1:0]    p_c;
    logic [PW-1:0]    ptr_adv;
    logic             nonempty;
    logic [3:0]       d_c;
    logic [TW-1:0]    period;
    logic [TW-1:0]    ticks_inc;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [PW-1:0]    ram_wdata;
    logic [PW-1:0]    ram_rdata;
    logic [PW-1:0]    cidx;
    logic [CNT_W-1:0] cnt_rd;
    logic [CNT_W-1:0] cur_c;
    logic [1:0]       stat_c;
    logic [CNT_W-1:0] snap_c;

    // ports in use, clamped to 1..MAX_PORTS
    always_comb begin
        pc_ext = CW'(port_count_reg);
        if (port_count_reg == 5'd0) begin
            n_c = CW'(1);
        end else if (pc_ext > CW'(MAX_PORTS)) begin
            n_c = CW'(MAX_PORTS);
        end else begin
            n_c = pc_ext;
        end
    end

    assign pi       = PW'(port_reg);
    assign port_bad = CW'(port_reg) >= n_c;
    assign ld_bad   = port_bad || (dest_reg == 5'd0) || (CW'(dest_reg) > n_c);
    assign ld_full  = fill_reg[pi] >= FW'(INPUT_DEPTH);

    // tail slot: head + fill stays below twice the depth
    assign slot_sum = (HW+1)'(head_reg[pi]) + (HW+1)'(fill_reg[pi]);
    assign slot     = (slot_sum >= (HW+1)'(INPUT_DEPTH)) ?
                      HW'(slot_sum - (HW+1)'(INPUT_DEPTH)) : HW'(slot_sum);

    assign p_c      = (CW'(ptr_reg) >= n_c) ? '0 : ptr_reg;
    assign ptr_adv  = (CW'(p_c) + CW'(1) >= n_c) ? '0 : p_c + PW'(1);
    assign nonempty = fill_reg[p_c] != '0;

    assign d_c       = (delay_reg == 4'd0) ? 4'd1 : delay_reg;
    assign period    = TW'(d_c) * TW'(n_c);
    assign ticks_inc = ticks_reg + TW'(1);

    assign ram_we    = cmd.push && !ld_bad && !ld_full;
    assign ram_waddr = AW'(pi) * AW'(INPUT_DEPTH) + AW'(slot);
    assign ram_wdata = PW'(dest_reg - 5'd1);
    assign ram_raddr = AW'(p_c) * AW'(INPUT_DEPTH) + AW'(head_reg[p_c]);

    oqsc_ram #(
        .WIDTH (PW),
        .DEPTH (MAX_PORTS * INPUT_DEPTH)
    ) u_fifo_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cidx   = cmd.drain_step ? sweep_reg : ram_rdata;
    assign cnt_rd = cnt_reg[cidx];
    assign cur_c  = (tot_reg > TOTW'(COUNT_MAX)) ? CNT_W'(COUNT_MAX) : CNT_W'(tot_reg);

    always_comb begin
        stat_c = ST_OK;
        snap_c = '0;
        if (kind_reg == KIND_LOAD) begin
            stat_c = status_reg;
        end else if (kind_reg == KIND_READ) begin
            if (port_bad) begin
                stat_c = ST_BAD;
            end else begin
                snap_c = snap_reg[pi];
            end
        end
    end

    assign sts.kind       = kind_reg;
    assign sts.drain_pend = drain_pend_reg;
    assign sts.sweep_last = CW'(sweep_reg) == n_c - CW'(1);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            port_count_reg <= 5'd16;
            delay_reg      <= 4'd3;
            for (int i = 0; i < MAX_PORTS; i++) begin
                head_reg[i] <= '0;
                fill_reg[i] <= '0;
                cnt_reg[i]  <= '0;
                snap_reg[i] <= '0;
            end
            tot_reg        <= '0;
            cur_reg        <= '0;
            max_reg        <= '0;
            ptr_reg        <= '0;
            ticks_reg      <= '0;
            sweep_reg      <= '0;
            pop_pend_reg   <= 1'b0;
            drain_pend_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                if (cfg_addr == REG_PORT_COUNT) begin
                    port_count_reg <= cfg_data;
                end else if (cfg_addr == REG_DELAY) begin
                    delay_reg <= cfg_data[3:0];
                end
            end
            if (ram_we) begin
                fill_reg[pi] <= fill_reg[pi] + FW'(1);
            end
            if (cmd.tick_step) begin
                pop_pend_reg <= nonempty;
                if (nonempty) begin
                    head_reg[p_c] <= (head_reg[p_c] == HW'(INPUT_DEPTH - 1)) ?
                                     '0 : head_reg[p_c] + HW'(1);
                    fill_reg[p_c] <= fill_reg[p_c] - FW'(1);
                end
                ptr_reg <= ptr_adv;
                if (ticks_inc >= period) begin
                    ticks_reg      <= '0;
                    drain_pend_reg <= 1'b1;
                end else begin
                    ticks_reg      <= ticks_inc;
                    drain_pend_reg <= 1'b0;
                end
            end
            if (cmd.pop_apply && pop_pend_reg && (cnt_rd != CNT_W'(COUNT_MAX))) begin
                cnt_reg[cidx] <= cnt_rd + CNT_W'(1);
                tot_reg       <= tot_reg + TOTW'(1);
            end
            if (cmd.drain_step) begin
                if (cnt_rd != '0) begin
                    cnt_reg[cidx] <= cnt_rd - CNT_W'(1);
                    tot_reg       <= tot_reg - TOTW'(1);
                end
                sweep_reg <= sts.sweep_last ? '0 : sweep_reg + PW'(1);
            end
            if (cmd.snap_eval) begin
                cur_reg <= cur_c;
                if (cur_c > max_reg) begin
                    max_reg <= cur_c;
                    for (int i = 0; i < MAX_PORTS; i++) begin
                        snap_reg[i] <= cnt_reg[i];
                    end
                end
            end
            if (cmd.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            kind_reg <= s_tuser;
            port_reg <= s_tdata[3:0];
            dest_reg <= s_tdata[8:4];
            upd_reg  <= 1'b0;
        end
        if (cmd.push) begin
            status_reg <= ld_bad ? ST_BAD : (ld_full ? ST_FULL : ST_OK);
        end
        if (cmd.snap_eval) begin
            upd_reg <= cur_c > max_reg;
        end
        if (cmd.emit) begin
            m_tdata_reg <= {3'b000, snap_c, (cur_reg == '0), upd_reg,
                            max_reg, cur_reg, stat_c};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

// ===== hdl/output_queued_switch_congestion_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// output_queued_switch_congestion_core
// Output-queued switch congestion model: per-port input FIFOs, round-robin
// service, periodic output drain and max-total snapshot.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_tvalid/s_tready  | tuser kind, tdata port, dest
//  m_      | out       | m_tvalid/m_tready  | tdata result fields
//  cfg_    | in        | cfg_we             | cfg_addr, cfg_data
//
//  Transaction steps: load, read and unused kinds go through dispatch and
//  response; a tick adds tick, pop and snapshot, plus a drain sweep over the
//  ports in use when the drain period expires (the sweep visits one output
//  counter per cycle). The registered RAM read gives the pop its own state.
//  Reset is synchronous, active low; counters, snapshot and FIFO pointers
//  clear at once, no clearing pass.
//  A stalled m_ side holds the result register; the next transaction is
//  accepted and worked up to its result while the previous one waits.
// ----------------------------------------------------------------------------
module output_queued_switch_congestion_core import oqsc_pkg::*; #(
    parameter int MAX_PORTS   = MAX_PORTS_DEF,
    parameter int INPUT_DEPTH = INPUT_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input transactions
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // port[3:0], destination[8:4]
    input  wire logic [1:0]            s_tuser,   // kind[1:0]
    // results
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,   // status[1:0], total_queued[12:2],
                                                  // max_total[23:13], max_updated[24],
                                                  // all_empty[25], snapshot_count[36:26]
    // configuration: 0 port_count, 1 delay_per_port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    oqsc_cmd_t cmd;
    oqsc_sts_t sts;

    // sequencer
    oqsc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // FIFOs, counters, snapshot, result register
    oqsc_datapath #(
        .MAX_PORTS   (MAX_PORTS),
        .INPUT_DEPTH (INPUT_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg_we   (cfg_we),
        .cfg_addr (cfg_addr),
        .cfg_data (cfg_data),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule
`default_nettype wire
